// ===== hw/rtl/rsft_pkg.sv =====
// Shared types, codes and helper functions of the range selection flag table.
package rsft_pkg;

    localparam int FLAG_W   = 3;
    localparam int MODE_W   = 4;
    localparam int IDX_W    = 11;
    localparam int STATUS_W = 2;

    typedef logic [FLAG_W-1:0] t_flag;

    // Selection codes as stored in the table.
    localparam t_flag CODE_NO_MAYBE   = 3'd0;
    localparam t_flag CODE_YES_MAYBE  = 3'd1;
    localparam t_flag CODE_YES_ALWAYS = 3'd2;
    localparam t_flag CODE_NO_ALWAYS  = 3'd3;
    localparam t_flag CODE_TOP        = 3'd4;
    localparam t_flag CODE_BOTTOM     = 3'd5;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] OP_SET_SCAN   = 4'd0;
    localparam logic [MODE_W-1:0] OP_SET        = 4'd1;
    localparam logic [MODE_W-1:0] OP_SCAN       = 4'd2;
    localparam logic [MODE_W-1:0] OP_CYCLE      = 4'd3;
    localparam logic [MODE_W-1:0] OP_TOGGLE     = 4'd4;
    localparam logic [MODE_W-1:0] OP_CLEAR      = 4'd5;
    localparam logic [MODE_W-1:0] OP_ALL        = 4'd6;
    localparam logic [MODE_W-1:0] OP_INSERT     = 4'd7;
    localparam logic [MODE_W-1:0] OP_REMOVE     = 4'd8;
    localparam logic [MODE_W-1:0] OP_DELETE     = 4'd9;
    localparam logic [MODE_W-1:0] OP_RESIZE     = 4'd10;
    localparam logic [MODE_W-1:0] OP_RESIZE_CLR = 4'd11;
    localparam logic [MODE_W-1:0] OP_QUERY      = 4'd12;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INDEX    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAPACITY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  entry_index;
        t_flag             flag_code;
        logic [IDX_W-1:0]  new_count;
    } t_req;

    typedef struct packed {
        t_flag               flag_out;
        logic                is_chosen;
        logic [IDX_W-1:0]    chosen_total;
        logic [IDX_W-1:0]    element_total;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // Control of the shared scan unit.
    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

    function automatic logic code_selected(t_flag c);
        return (c == CODE_YES_MAYBE) || (c == CODE_YES_ALWAYS) ||
               (c == CODE_TOP) || (c == CODE_BOTTOM);
    endfunction

    // Codes that mean nothing are stored as inherit-no.
    function automatic t_flag flag_sanitize(t_flag c);
        return (c > CODE_BOTTOM) ? CODE_NO_MAYBE : c;
    endfunction

    function automatic t_flag cycle_next(t_flag c);
        t_flag r;
        unique case (c) inside
            CODE_NO_MAYBE, CODE_YES_MAYBE: r = CODE_YES_ALWAYS;
            CODE_YES_ALWAYS:               r = CODE_NO_ALWAYS;
            CODE_NO_ALWAYS:                r = CODE_TOP;
            CODE_TOP:                      r = CODE_BOTTOM;
            default:                       r = CODE_NO_MAYBE;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/range_selection_flag_table.sv =====
// Top level of the range selection flag table: sequencer, counters and result register.
//
// The block keeps one selection code per element in a single table memory with
// one write and one registered read port, and it works on one request at a time.
// A request that touches no table entries (query, clear, delete, resize, or any
// request that is rejected with an index or capacity status) passes from
// acceptance through the decode, read and done states to its result. Every pass
// over the table runs through that one memory port pair at one entry per cycle:
// the first write to an unallocated table fills it with inherit-no over the
// element count, a propagation scan reads and rewrites every entry, and an
// insert or remove first shifts the entries behind the index before its scan.
// There is no clearing pass after reset; the table is filled when it first
// becomes allocated. A new request is accepted while the previous result still
// waits in the output register, and the sequencer holds its final step until
// that register is free.
module range_selection_flag_table #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  rsft_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output rsft_pkg::t_rsp o_rsp
);

    // Address width of the table and width of the element and selected counts.
    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = rsft_pkg::IDX_W;
    localparam int CMPW = (CW > IW) ? CW : IW;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_FILL    = 4'd2;
    localparam logic [3:0] S_MOD_RD  = 4'd3;
    localparam logic [3:0] S_MOD_WR  = 4'd4;
    localparam logic [3:0] S_TOG_RD  = 4'd5;
    localparam logic [3:0] S_TOG_CHK = 4'd6;
    localparam logic [3:0] S_PASS    = 4'd7;
    localparam logic [3:0] S_READ    = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    // Kinds of table pass.
    localparam logic [1:0] K_SCAN = 2'd0;
    localparam logic [1:0] K_UP   = 2'd1;
    localparam logic [1:0] K_DOWN = 2'd2;

    logic [3:0]                   r_state, n_state;
    logic                         r_valid, n_valid;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_sel, n_sel;
    logic [1:0]                   r_kind, n_kind;
    logic                         r_pend, n_pend;
    logic [CW-1:0]                r_ptr, n_ptr;
    logic [AW-1:0]                r_wptr, n_wptr;
    logic                         r_fill_top, n_fill_top;
    rsft_pkg::t_req               r_req, n_req;
    logic [rsft_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_rsp_valid, n_rsp_valid;
    rsft_pkg::t_rsp               r_rsp;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    rsft_pkg::t_flag     w_wdata;
    logic [AW-1:0]       w_raddr;
    rsft_pkg::t_flag     w_rdata;
    rsft_pkg::t_scan_ctl w_scan_ctl;
    rsft_pkg::t_flag     w_scan_code;
    logic [CW-1:0]       w_scan_total;
    logic                w_rd_en;
    logic                w_go_scan;
    logic                w_go_all;
    logic                w_load;
    logic                w_hit;

    // Widened copies so that index, count and capacity compare at one width.
    logic [CMPW-1:0] w_idx_x;
    logic [CMPW-1:0] w_cnt_x;
    logic [CMPW-1:0] w_new_x;
    logic [CMPW-1:0] w_ptr_x;
    logic [CMPW-1:0] w_max_x;
    logic            w_idx_in;

    assign w_idx_x  = CMPW'(r_req.entry_index);
    assign w_cnt_x  = CMPW'(r_count);
    assign w_new_x  = CMPW'(r_req.new_count);
    assign w_ptr_x  = CMPW'(r_ptr);
    assign w_max_x  = CMPW'(MAX_ENTRIES);
    assign w_idx_in = (w_idx_x < w_cnt_x);
    assign w_hit    = w_idx_in && r_valid;

    rsft_flag_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rsft_scan_unit #(
        .TOTAL_W (CW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scan_ctl),
        .i_code  (w_rdata),
        .o_code  (w_scan_code),
        .o_total (w_scan_total)
    );

    // The block takes a new request only when the sequencer is idle.
    assign o_req_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_sel       = r_sel;
        n_kind      = r_kind;
        n_pend      = r_pend;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_fill_top  = r_fill_top;
        n_req       = r_req;
        n_status    = r_status;
        w_we        = 1'b0;
        w_waddr     = AW'(r_req.entry_index);
        w_wdata     = rsft_pkg::CODE_NO_MAYBE;
        w_raddr     = AW'(r_req.entry_index);
        w_scan_ctl  = '0;
        w_rd_en     = 1'b0;
        w_go_scan   = 1'b0;
        w_go_all    = 1'b0;
        w_load      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req           = i_req;
                    n_req.flag_code = rsft_pkg::flag_sanitize(i_req.flag_code);
                    n_state         = S_DECODE;
                end
            end

            S_DECODE: begin
                // Requests that touch no table entries fall through to the result read.
                n_status = rsft_pkg::ST_OK;
                n_state  = S_READ;
                unique case (r_req.mode) inside
                    rsft_pkg::OP_SET_SCAN, rsft_pkg::OP_SET, rsft_pkg::OP_CYCLE: begin
                        if (!w_idx_in) begin
                            n_status = rsft_pkg::ST_INDEX;
                        end else if (!r_valid) begin
                            n_ptr      = '0;
                            n_fill_top = 1'b0;
                            n_state    = S_FILL;
                        end else begin
                            n_state = S_MOD_RD;
                        end
                    end
                    rsft_pkg::OP_SCAN: begin
                        w_go_scan = r_valid;
                    end
                    rsft_pkg::OP_TOGGLE: begin
                        if (r_count != '0) begin
                            if (!r_valid) begin
                                w_go_all = 1'b1;
                            end else begin
                                n_state = S_TOG_RD;
                            end
                        end
                    end
                    rsft_pkg::OP_CLEAR: begin
                        n_valid = 1'b0;
                        n_sel   = '0;
                    end
                    rsft_pkg::OP_ALL: begin
                        w_go_all = 1'b1;
                    end
                    rsft_pkg::OP_INSERT: begin
                        if (w_idx_x > w_cnt_x) begin
                            n_status = rsft_pkg::ST_INDEX;
                        end else if (w_cnt_x >= w_max_x) begin
                            n_status = rsft_pkg::ST_CAPACITY;
                        end else if (!r_valid) begin
                            n_count = r_count + CW'(1);
                        end else begin
                            n_kind  = K_UP;
                            n_ptr   = r_count;
                            n_pend  = 1'b0;
                            n_state = S_PASS;
                        end
                    end
                    rsft_pkg::OP_REMOVE: begin
                        if (!w_idx_in) begin
                            n_status = rsft_pkg::ST_INDEX;
                        end else if (!r_valid) begin
                            n_count = r_count - CW'(1);
                        end else if (r_count == CW'(1)) begin
                            n_valid = 1'b0;
                            n_count = '0;
                            n_sel   = '0;
                        end else begin
                            n_kind  = K_DOWN;
                            n_ptr   = CW'(w_idx_x + CMPW'(1));
                            n_pend  = 1'b0;
                            n_state = S_PASS;
                        end
                    end
                    rsft_pkg::OP_DELETE: begin
                        n_valid = 1'b0;
                        n_count = '0;
                        n_sel   = '0;
                    end
                    rsft_pkg::OP_RESIZE, rsft_pkg::OP_RESIZE_CLR: begin
                        if (w_new_x > w_max_x) begin
                            n_status = rsft_pkg::ST_CAPACITY;
                        end else if (!((r_req.mode == rsft_pkg::OP_RESIZE) &&
                                       (w_new_x == w_cnt_x))) begin
                            n_valid = 1'b0;
                            n_count = CW'(r_req.new_count);
                            n_sel   = '0;
                        end
                    end
                    rsft_pkg::OP_QUERY: begin
                        if (!w_idx_in) begin
                            n_status = rsft_pkg::ST_INDEX;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_FILL: begin
                // Allocation: inherit-no over the count, range-top at the head for select all.
                w_we    = 1'b1;
                w_waddr = AW'(r_ptr);
                w_wdata = (r_fill_top && (r_ptr == '0)) ? rsft_pkg::CODE_TOP
                                                        : rsft_pkg::CODE_NO_MAYBE;
                n_ptr   = r_ptr + CW'(1);
                if ((w_ptr_x + CMPW'(1)) == w_cnt_x) begin
                    n_valid = 1'b1;
                    if (r_fill_top) begin
                        w_go_scan = 1'b1;
                    end else begin
                        n_state = S_MOD_RD;
                    end
                end
            end

            S_MOD_RD: begin
                n_state = S_MOD_WR;
            end

            S_MOD_WR: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_req.entry_index);
                w_wdata = (r_req.mode == rsft_pkg::OP_CYCLE) ? rsft_pkg::cycle_next(w_rdata)
                                                             : r_req.flag_code;
                if (r_req.mode == rsft_pkg::OP_SET) begin
                    n_state = S_READ;
                end else begin
                    w_go_scan = 1'b1;
                end
            end

            S_TOG_RD: begin
                w_raddr = '0;
                n_state = S_TOG_CHK;
            end

            S_TOG_CHK: begin
                if (rsft_pkg::code_selected(w_rdata)) begin
                    n_valid = 1'b0;
                    n_sel   = '0;
                    n_state = S_READ;
                end else begin
                    w_go_all = 1'b1;
                end
            end

            S_PASS: begin
                // Reads run one entry ahead of the writes; the data read last cycle
                // is written back this cycle to its own or a neighboring entry.
                unique case (r_kind)
                    K_UP: begin
                        w_rd_en = (w_ptr_x > w_idx_x);
                        w_raddr = AW'(r_ptr - CW'(1));
                        if (w_rd_en) begin
                            n_ptr  = r_ptr - CW'(1);
                            n_wptr = AW'(r_ptr);
                        end
                    end
                    K_DOWN: begin
                        w_rd_en = (w_ptr_x < w_cnt_x);
                        w_raddr = AW'(r_ptr);
                        if (w_rd_en) begin
                            n_ptr  = r_ptr + CW'(1);
                            n_wptr = AW'(r_ptr - CW'(1));
                        end
                    end
                    default: begin
                        w_rd_en = (w_ptr_x < w_cnt_x);
                        w_raddr = AW'(r_ptr);
                        if (w_rd_en) begin
                            n_ptr  = r_ptr + CW'(1);
                            n_wptr = AW'(r_ptr);
                        end
                    end
                endcase
                n_pend          = w_rd_en;
                w_scan_ctl.step = r_pend && (r_kind == K_SCAN);
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_wptr;
                    w_wdata = (r_kind == K_SCAN) ? w_scan_code : w_rdata;
                end
                if (!w_rd_en && !r_pend) begin
                    unique case (r_kind)
                        K_UP: begin
                            // The opened slot gets inherit-no before the rescan.
                            w_we      = 1'b1;
                            w_waddr   = AW'(r_req.entry_index);
                            w_wdata   = rsft_pkg::CODE_NO_MAYBE;
                            n_count   = r_count + CW'(1);
                            w_go_scan = 1'b1;
                        end
                        K_DOWN: begin
                            n_count   = r_count - CW'(1);
                            w_go_scan = 1'b1;
                        end
                        default: begin
                            n_sel   = w_scan_total;
                            n_state = S_READ;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Select all: drop the table, then, if it has elements, reallocate with range-top at the head.
        if (w_go_all) begin
            n_valid = 1'b0;
            n_sel   = '0;
            if (r_count != '0) begin
                n_ptr      = '0;
                n_fill_top = 1'b1;
                n_state    = S_FILL;
            end else begin
                n_state = S_READ;
            end
        end

        if (w_go_scan) begin
            n_kind           = K_SCAN;
            n_ptr            = '0;
            n_pend           = 1'b0;
            w_scan_ctl.start = 1'b1;
            n_state          = S_PASS;
        end
    end

    // The result register is free again once its result has been taken.
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (w_load) begin
            n_rsp_valid = 1'b1;
        end else if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_count     <= '0;
            r_sel       <= '0;
            r_kind      <= K_SCAN;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_sel       <= n_sel;
            r_kind      <= n_kind;
            r_pend      <= n_pend;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_wptr     <= n_wptr;
        r_fill_top <= n_fill_top;
        r_req      <= n_req;
        r_status   <= n_status;
        if (w_load) begin
            r_rsp.flag_out      <= w_hit ? w_rdata : rsft_pkg::CODE_NO_MAYBE;
            r_rsp.is_chosen     <= w_hit && rsft_pkg::code_selected(w_rdata);
            r_rsp.chosen_total  <= IW'(r_sel);
            r_rsp.element_total <= IW'(r_count);
            r_rsp.status        <= r_status;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== hw/rtl/rsft_flag_mem.sv =====
// Flag table storage: one write port and one registered read port.
module rsft_flag_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  rsft_pkg::t_flag i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output rsft_pkg::t_flag o_rdata
);

    rsft_pkg::t_flag r_mem [DEPTH];
    rsft_pkg::t_flag r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rsft_scan_unit.sv =====
// Propagation scan unit: rewrites inherit codes and counts selected entries.
module rsft_scan_unit #(
    parameter int TOTAL_W = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsft_pkg::t_scan_ctl i_ctl,
    input  rsft_pkg::t_flag     i_code,
    output rsft_pkg::t_flag     o_code,
    output logic [TOTAL_W-1:0]  o_total
);

    // The running mode is one bit: inherit-yes when set, inherit-no when clear.
    logic               r_yes;
    logic               n_yes;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;

    always_comb begin
        if ((i_code == rsft_pkg::CODE_NO_MAYBE) || (i_code == rsft_pkg::CODE_YES_MAYBE)) begin
            o_code = r_yes ? rsft_pkg::CODE_YES_MAYBE : rsft_pkg::CODE_NO_MAYBE;
        end else begin
            o_code = i_code;
        end
    end

    always_comb begin
        n_yes   = r_yes;
        n_total = r_total;
        if (i_ctl.start) begin
            n_yes   = 1'b0;
            n_total = '0;
        end else if (i_ctl.step) begin
            if (i_code == rsft_pkg::CODE_TOP) begin
                n_yes = 1'b1;
            end else if (i_code == rsft_pkg::CODE_BOTTOM) begin
                n_yes = 1'b0;
            end
            if (rsft_pkg::code_selected(o_code)) begin
                n_total = r_total + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yes   <= 1'b0;
            r_total <= '0;
        end else begin
            r_yes   <= n_yes;
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

// ===== hw/rtl/rsft_checker.sv =====
// Port-level checker of the range selection flag table and its bind statement.
module rsft_checker #(
    parameter int MAX_ENTRIES = 1024
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_stall,
    input rsft_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input rsft_pkg::t_rsp o_rsp
);

    // A result waiting on a stalled consumer stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid)
        else $error("result withdrawn while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> $stable(o_rsp))
        else $error("stalled result changed");

    // Each request occupies the sequencer for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request accepted back to back");

    // Selected entries never outnumber the elements while counts fit the fields.
    a_sel_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (MAX_ENTRIES < 2048) |->
            o_rsp.chosen_total <= o_rsp.element_total)
        else $error("selected count exceeds element count");

    a_chosen_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.is_chosen |->
            (o_rsp.flag_out != rsft_pkg::CODE_NO_MAYBE) &&
            (o_rsp.flag_out != rsft_pkg::CODE_NO_ALWAYS))
        else $error("entry reported selected with a deselected code");

endmodule

bind range_selection_flag_table rsft_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (.*);
